### sv/sdg_pkg.sv
// Package: shared widths and constants for the segment step/dir generator.
`default_nettype none
package sdg_pkg;
    localparam int NAX = 6;
    localparam int AXES_DEF = 6;
    localparam int W = 32;
    localparam int TW = 33;
    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
endpackage
`default_nettype wire

### sv/sdg_div.sv
// Module: bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module sdg_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [sdg_pkg::W-1:0]   i_num,
    input  wire logic [sdg_pkg::W-1:0]   i_den,
    output logic                         o_done,
    output logic [sdg_pkg::W-1:0]        o_quo
);
    logic [sdg_pkg::W-1:0] r_q, n_q;
    logic [sdg_pkg::W:0]   r_rem, n_rem;
    logic [sdg_pkg::W-1:0] r_den;
    logic [5:0]            r_cnt, n_cnt;
    logic                  r_run, n_run;
    logic [sdg_pkg::W:0]   sh;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_run = r_run;
        sh    = {r_rem[sdg_pkg::W-1:0], r_q[sdg_pkg::W-1]};
        if (i_start) begin
            n_q   = i_num;
            n_rem = '0;
            n_cnt = 6'(sdg_pkg::W);
            n_run = 1'b1;
        end else if (r_run) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = sh - {1'b0, r_den};
                n_q   = {r_q[sdg_pkg::W-2:0], 1'b1};
            end else begin
                n_rem = sh;
                n_q   = {r_q[sdg_pkg::W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_run = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_run && (r_cnt == 6'd1);
    assign o_quo  = n_q;
endmodule
`default_nettype wire

### sv/segment_step_dir_generator_unit.sv
// Module: top level of the six-axis segment step/dir generator.
//
//  channel | dir | handshake      | payload
//  in      | in  | valid / stall  | func, halt, segment_length, axisN_steps
//  out     | out | valid / stall  | step_mask, dir_mask, busy_res, accepted, positions
//  cfg     | in  | valid / ready  | invert_mask
//
// A tick or a refused load goes straight to the result. A load visits each axis in
// turn, running the one serial divider for each moving axis and skipping it for idle
// ones; a load that ends at once clears busy before its result is shown. Synchronous
// active-low reset clears all state but step latches and divider data. Output stall
// holds the result; a new request is taken once the result register is free.
`default_nettype none
module segment_step_dir_generator_unit #(
    parameter int AXES = sdg_pkg::AXES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_func,
    input  wire logic                      i_halt,
    input  wire logic [31:0]               i_segment_length,
    input  wire logic signed [31:0]        i_axis0_steps,
    input  wire logic signed [31:0]        i_axis1_steps,
    input  wire logic signed [31:0]        i_axis2_steps,
    input  wire logic signed [31:0]        i_axis3_steps,
    input  wire logic signed [31:0]        i_axis4_steps,
    input  wire logic signed [31:0]        i_axis5_steps,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [5:0]                     o_step_mask,
    output logic [5:0]                     o_dir_mask,
    output logic                           o_busy_res,
    output logic                           o_accepted,
    output logic signed [31:0]             o_axis0_position,
    output logic signed [31:0]             o_axis1_position,
    output logic signed [31:0]             o_axis2_position,
    output logic signed [31:0]             o_axis3_position,
    output logic signed [31:0]             o_axis4_position,
    output logic signed [31:0]             o_axis5_position,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [5:0]                i_cfg_data
);
    localparam int N = sdg_pkg::NAX;
    localparam int W = sdg_pkg::W;
    localparam int TW = sdg_pkg::TW;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_st;
    logic [5:0]    r_inv;
    logic [TW-1:0] r_el;
    logic          r_act;
    logic [W-1:0]  r_dur;
    logic [W-1:0]  r_left [N];
    logic [W-1:0]  r_ivl  [N];
    logic [TW-1:0] r_due  [N];
    logic [N-1:0]  r_neg, r_dir;
    logic [W-1:0]  r_pos  [N];
    logic [W-1:0]  r_stp  [N];
    logic [2:0]    r_ax;
    logic [5:0]    r_smask;
    logic          r_acc;

    logic          div_start, div_done;
    logic [W-1:0]  div_quo, mag, ivl;
    logic          any_left;
    logic [W-1:0]  in_stp [N];

    assign in_stp[0] = i_axis0_steps;
    assign in_stp[1] = i_axis1_steps;
    assign in_stp[2] = i_axis2_steps;
    assign in_stp[3] = i_axis3_steps;
    assign in_stp[4] = i_axis4_steps;
    assign in_stp[5] = i_axis5_steps;

    wire load_end = r_acc && r_act && !any_left && (r_el >= TW'(r_dur));

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT) && !load_end;

    wire take = i_in_valid && (r_st == S_IDLE);
    wire cur_zero = (r_stp[r_ax] == '0);
    assign mag = r_stp[r_ax][W-1] ? (W'(0) - r_stp[r_ax]) : r_stp[r_ax];
    assign ivl = (div_quo == '0) ? W'(1) : div_quo;
    assign div_start = (r_st == S_DIV) && !cur_zero;

    sdg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dur),
        .i_den   (mag),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        any_left = 1'b0;
        for (int i = 0; i < AXES; i++) if (r_left[i] != '0) any_left = 1'b1;
    end

    wire last_ax = (r_ax == 3'(AXES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_inv <= '0;
            r_el <= '0;
            r_act <= 1'b0;
            r_dur <= '0;
            r_neg <= '0;
            r_dir <= '0;
            r_ax <= '0;
            r_smask <= '0;
            r_acc <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_left[i] <= '0;
                r_ivl[i] <= '0;
                r_due[i] <= '0;
                r_pos[i] <= '0;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid) r_inv <= i_cfg_data;
                    if (take) begin
                        if (i_func == sdg_pkg::FUNC_LOAD && !i_halt && !r_act) begin
                            r_smask <= '0;
                            r_acc <= 1'b1;
                            r_dur <= i_segment_length;
                            r_el <= '0;
                            r_act <= 1'b1;
                            r_ax <= '0;
                            for (int i = 0; i < N; i++) r_stp[i] <= in_stp[i];
                            r_st <= S_DIV;
                        end else begin
                            r_acc <= 1'b0;
                            r_st <= S_OUT;
                            if (i_func == sdg_pkg::FUNC_TICK && !i_halt && r_act) begin
                                logic [TW-1:0] el;
                                logic          left;
                                logic [5:0]    sm;
                                el = (r_el != sdg_pkg::T_MAX) ? r_el + TW'(1) : r_el;
                                left = 1'b0;
                                sm = '0;
                                r_el <= el;
                                for (int i = 0; i < AXES; i++) begin
                                    if (r_left[i] != '0 && r_due[i] <= el) begin
                                        sm[i] = 1'b1;
                                        r_pos[i] <= r_pos[i] + (r_neg[i] ? {W{1'b1}} : W'(1));
                                        r_left[i] <= r_left[i] - W'(1);
                                        r_due[i] <= r_due[i] + TW'(r_ivl[i]);
                                        if (r_left[i] != W'(1)) left = 1'b1;
                                    end else if (r_left[i] != '0) left = 1'b1;
                                end
                                r_smask <= sm;
                                if (!left && el >= TW'(r_dur)) r_act <= 1'b0;
                            end else begin
                                r_smask <= '0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (cur_zero) begin
                        r_left[r_ax] <= '0;
                        r_ivl[r_ax] <= {W{1'b1}};
                        r_due[r_ax] <= TW'({W{1'b1}});
                        r_neg[r_ax] <= 1'b0;
                        if (last_ax) r_st <= S_OUT;
                        r_ax <= r_ax + 3'd1;
                    end else r_st <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_neg[r_ax] <= r_stp[r_ax][W-1];
                        r_dir[r_ax] <= !r_stp[r_ax][W-1] ^ r_inv[r_ax];
                        r_left[r_ax] <= mag;
                        r_ivl[r_ax] <= ivl;
                        r_due[r_ax] <= TW'(ivl >> 1);
                        r_ax <= r_ax + 3'd1;
                        r_st <= last_ax ? S_OUT : S_DIV;
                    end
                end
                S_OUT: begin
                    if (load_end) r_act <= 1'b0;
                    else if (!i_out_stall) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_step_mask = r_smask;
        o_dir_mask = '0;
        for (int i = 0; i < AXES; i++) o_dir_mask[i] = r_dir[i];
        o_busy_res = r_act;
        o_accepted = r_acc;
    end

    assign o_axis0_position = (0 < AXES) ? r_pos[0] : '0;
    assign o_axis1_position = (1 < AXES) ? r_pos[1] : '0;
    assign o_axis2_position = (2 < AXES) ? r_pos[2] : '0;
    assign o_axis3_position = (3 < AXES) ? r_pos[3] : '0;
    assign o_axis4_position = (4 < AXES) ? r_pos[4] : '0;
    assign o_axis5_position = (5 < AXES) ? r_pos[5] : '0;
endmodule
`default_nettype wire

### tb/sv/segment_step_dir_checker.sv
// Checker: predicts step/dir generator results and compares every accepted result.
`timescale 1ns / 100ps
module segment_step_dir_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_func,
    input  logic              i_halt,
    input  logic [31:0]       i_segment_length,
    input  logic [5:0][31:0]  i_steps,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [5:0]        i_step_mask,
    input  logic [5:0]        i_dir_mask,
    input  logic              i_busy_res,
    input  logic              i_accepted,
    input  logic [5:0][31:0]  i_position,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [5:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [5:0]       step_mask;
        logic [5:0]       dir_mask;
        logic             busy;
        logic             accepted;
        logic [5:0][31:0] position;
    } motion_result_t;

    motion_result_t result_q[$];

    logic [5:0]            invert_mask;
    logic [sdg_pkg::TW-1:0] elapsed;
    logic                  active;
    logic [31:0]           duration;
    logic [31:0]           steps_left [sdg_pkg::NAX];
    logic [31:0]           interval [sdg_pkg::NAX];
    logic [sdg_pkg::TW-1:0] due [sdg_pkg::NAX];
    logic                  move_neg [sdg_pkg::NAX];
    logic                  dir_level [sdg_pkg::NAX];
    logic [31:0]           pos [sdg_pkg::NAX];

    function automatic void end_if_done();
        logic remaining;
        remaining = 1'b0;
        for (int i = 0; i < sdg_pkg::NAX; i++) begin
            if (steps_left[i] != 0) remaining = 1'b1;
        end
        if (active && !remaining && elapsed >= {1'b0, duration}) active = 1'b0;
    endfunction

    function automatic motion_result_t advance_motion(input logic func, input logic halt,
                                                      input logic [31:0] len,
                                                      input logic [5:0][31:0] steps);
        motion_result_t r;
        logic [31:0] raw;
        logic [31:0] mag;
        r = '0;
        if (func == sdg_pkg::FUNC_LOAD) begin
            if (!halt && !active) begin
                r.accepted = 1'b1;
                duration = len;
                elapsed = '0;
                active = 1'b1;
                for (int i = 0; i < sdg_pkg::NAX; i++) begin
                    raw = steps[i];
                    if (raw == 0) begin
                        steps_left[i] = 0;
                        interval[i] = 32'hFFFF_FFFF;
                        due[i] = {1'b0, 32'hFFFF_FFFF};
                        move_neg[i] = 1'b0;
                    end else begin
                        mag = raw[31] ? (32'd0 - raw) : raw;
                        move_neg[i] = raw[31];
                        dir_level[i] = (!raw[31]) ^ invert_mask[i];
                        steps_left[i] = mag;
                        interval[i] = duration / mag;
                        if (interval[i] == 0) interval[i] = 1;
                        due[i] = {1'b0, interval[i] >> 1};
                    end
                end
                end_if_done();
            end
        end else if (!halt && active) begin
            if (elapsed != sdg_pkg::T_MAX) elapsed = elapsed + 1'b1;
            for (int i = 0; i < sdg_pkg::NAX; i++) begin
                if (steps_left[i] != 0 && due[i] <= elapsed) begin
                    r.step_mask[i] = 1'b1;
                    pos[i] = move_neg[i] ? pos[i] - 1 : pos[i] + 1;
                    steps_left[i] = steps_left[i] - 1;
                    due[i] = due[i] + {1'b0, interval[i]};
                end
            end
            end_if_done();
        end
        for (int i = 0; i < sdg_pkg::NAX; i++) begin
            r.dir_mask[i] = dir_level[i];
            r.position[i] = pos[i];
        end
        r.busy = active;
        return r;
    endfunction

    always @(posedge i_clk) begin
        motion_result_t exp_r;
        if (!i_rst_n) begin
            result_q.delete();
            invert_mask = '0;
            elapsed = '0;
            active = 1'b0;
            duration = '0;
            for (int i = 0; i < sdg_pkg::NAX; i++) begin
                steps_left[i] = 0;
                interval[i] = 0;
                due[i] = 0;
                move_neg[i] = 1'b0;
                dir_level[i] = 1'b0;
                pos[i] = 0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) invert_mask = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(advance_motion(i_func, i_halt, i_segment_length, i_steps));
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result with no request pending");
                    o_fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (i_step_mask !== exp_r.step_mask) begin
                        $error("step_mask: expected %h, got %h", exp_r.step_mask, i_step_mask);
                        o_fail_count++;
                    end
                    if (i_dir_mask !== exp_r.dir_mask) begin
                        $error("dir_mask: expected %h, got %h", exp_r.dir_mask, i_dir_mask);
                        o_fail_count++;
                    end
                    if (i_busy_res !== exp_r.busy) begin
                        $error("busy_res: expected %b, got %b", exp_r.busy, i_busy_res);
                        o_fail_count++;
                    end
                    if (i_accepted !== exp_r.accepted) begin
                        $error("accepted: expected %b, got %b", exp_r.accepted, i_accepted);
                        o_fail_count++;
                    end
                    for (int i = 0; i < sdg_pkg::NAX; i++) begin
                        if (i_position[i] !== exp_r.position[i]) begin
                            $error("axis%0d_position: expected %h, got %h", i,
                                   exp_r.position[i], i_position[i]);
                            o_fail_count++;
                        end
                    end
                end
            end
        end
        o_pending = result_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

### tb/sv/tb.sv
// Testbench top: drives requests and configuration into the step/dir generator.
`timescale 1ns / 100ps
module tb;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 250;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_func = sdg_pkg::FUNC_TICK;
    logic             i_halt = 1'b0;
    logic [31:0]      i_segment_length = '0;
    logic [5:0][31:0] i_steps = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [5:0]       o_step_mask;
    logic [5:0]       o_dir_mask;
    logic             o_busy_res;
    logic             o_accepted;
    logic [5:0][31:0] o_position;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [5:0]       i_cfg_data = '0;

    int  fail_count;
    int  pending;
    int  send_idle = 0;
    int  recv_idle = 0;
    int  sent = 0;
    int  cycles = 0;
    logic long_hold = 1'b0;

    segment_step_dir_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_halt(i_halt), .i_segment_length(i_segment_length),
        .i_axis0_steps(i_steps[0]), .i_axis1_steps(i_steps[1]), .i_axis2_steps(i_steps[2]),
        .i_axis3_steps(i_steps[3]), .i_axis4_steps(i_steps[4]), .i_axis5_steps(i_steps[5]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_step_mask(o_step_mask), .o_dir_mask(o_dir_mask),
        .o_busy_res(o_busy_res), .o_accepted(o_accepted),
        .o_axis0_position(o_position[0]), .o_axis1_position(o_position[1]),
        .o_axis2_position(o_position[2]), .o_axis3_position(o_position[3]),
        .o_axis4_position(o_position[4]), .o_axis5_position(o_position[5]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    segment_step_dir_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_func(i_func), .i_halt(i_halt), .i_segment_length(i_segment_length),
        .i_steps(i_steps),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_step_mask(o_step_mask), .i_dir_mask(o_dir_mask),
        .i_busy_res(o_busy_res), .i_accepted(o_accepted), .i_position(o_position),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= long_hold || ($urandom_range(99) < recv_idle);
        end
    end

    // hold the result side off long enough to back up the input
    initial begin
        repeat (3000) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (500) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    function automatic logic [5:0][31:0] random_steps();
        logic [5:0][31:0] s;
        for (int i = 0; i < 6; i++) s[i] = $urandom;
        return s;
    endfunction

    task automatic send(input logic func, input logic halt, input logic [31:0] len,
                        input logic [5:0][31:0] steps);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_halt <= halt;
        i_segment_length <= len;
        i_steps <= steps;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_invert(input logic [5:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // load a segment, then tick it to completion with refused loads and halts mixed in
    task automatic run_segment(input int dur_hi, input int mag_hi);
        logic [5:0][31:0] steps;
        int dur;
        int need;
        int mag;
        int done;
        int r;
        dur = $urandom_range(dur_hi, 0);
        need = dur;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(3) == 0) begin
                steps[i] = 0;
            end else begin
                mag = $urandom_range(mag_hi, 1);
                steps[i] = $urandom_range(1) ? -mag : mag;
                if (mag > need) need = mag;
            end
        end
        send(sdg_pkg::FUNC_LOAD, 1'b0, dur, steps);
        done = 0;
        while (done < need) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send(sdg_pkg::FUNC_LOAD, 1'($urandom_range(1)), $urandom, random_steps());
            end else if (r < 12) begin
                send(sdg_pkg::FUNC_TICK, 1'b1, $urandom, random_steps());
            end else begin
                send(sdg_pkg::FUNC_TICK, 1'b0, $urandom, random_steps());
                done++;
            end
        end
        if ($urandom_range(3) == 0) begin
            send(sdg_pkg::FUNC_TICK, 1'($urandom_range(1)), $urandom, random_steps());
        end
    endtask

    task automatic run_phase(input int target);
        int r;
        target = sent + target;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 80) begin
                run_segment(30, 30);
            end else if (r < 88) begin
                run_segment(150, 40);
            end else if (r < 94) begin
                send(sdg_pkg::FUNC_LOAD, 1'b1, $urandom, random_steps());
            end else begin
                send(sdg_pkg::FUNC_TICK, 1'($urandom_range(1)), $urandom, random_steps());
            end
        end
    endtask

    initial begin
        logic [5:0][31:0] s;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_invert(6'h00);

        s = random_steps();
        send(sdg_pkg::FUNC_TICK, 1'b0, 32'hFFFF_FFFF, s);
        send(sdg_pkg::FUNC_TICK, 1'b1, 32'h0, ~s);
        s = {32'h8000_0001, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send(sdg_pkg::FUNC_LOAD, 1'b1, 32'hFFFF_FFFF, s);
        send(sdg_pkg::FUNC_LOAD, 1'b0, 32'h0, '0);
        s = {32'd1, -32'sd12, 32'd12, 32'd0, -32'sd2, 32'd3};
        send(sdg_pkg::FUNC_LOAD, 1'b0, 32'd10, s);
        send(sdg_pkg::FUNC_TICK, 1'b1, 32'h0, '0);
        s = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
        send(sdg_pkg::FUNC_LOAD, 1'b0, 32'hFFFF_FFFF, s);
        repeat (12) send(sdg_pkg::FUNC_TICK, 1'b0, 32'h0, '0);
        send(sdg_pkg::FUNC_LOAD, 1'b0, 32'd5, '0);
        repeat (5) send(sdg_pkg::FUNC_TICK, 1'b0, 32'h0, '0);
        s = {32'd2, 32'd0, 32'd0, 32'd0, -32'sd1, 32'd1};
        send(sdg_pkg::FUNC_LOAD, 1'b0, 32'd0, s);
        repeat (3) send(sdg_pkg::FUNC_TICK, 1'b0, 32'h0, '0);

        write_invert(6'h3F);
        send_idle = 35;
        recv_idle = 50;
        run_phase(600);

        write_invert(6'($urandom));
        send_idle = 50;
        recv_idle = 35;
        run_phase(600);

        write_invert(6'h2A);
        send_idle = 0;
        recv_idle = 0;
        run_phase(600);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
